// File: hdl/isaac_pkg.sv
// Shared types and constants for the ISAAC keystream generator.
package isaac_pkg;

	localparam logic [31:0] GOLDEN = 32'h9E3779B9;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_INIT = 2'd1,
		OP_DRAW = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCR,
		ST_MRD,
		ST_MADD,
		ST_MSCR,
		ST_MWR,
		ST_RF_RD,
		ST_RF_A,
		ST_RF_Y,
		ST_RF_B,
		ST_RF_W,
		ST_RF_P,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} state_t;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] vec8_t;

	// One step of the eight-word scramble (steps 0..7).
	function automatic vec8_t scramble_step(input vec8_t v, input logic [2:0] s);
		vec8_t r;
		logic [2:0] p0, p1, p2, p3;
		word_t t;
		r = v;
		p0 = s;
		p1 = s + 3'd1;
		p2 = s + 3'd2;
		p3 = s + 3'd3;
		case (s)
			3'd0: t = r[p1] << 11;
			3'd1: t = r[p1] >> 2;
			3'd2: t = r[p1] << 8;
			3'd3: t = r[p1] >> 16;
			3'd4: t = r[p1] << 10;
			3'd5: t = r[p1] >> 4;
			3'd6: t = r[p1] << 8;
			default: t = r[p1] >> 9;
		endcase
		r[p0] = r[p0] ^ t;
		r[p3] = r[p3] + r[p0];
		r[p1] = r[p1] + r[p2];
		return r;
	endfunction

endpackage

// File: hdl/isaac_keystream_generator.sv
// ISAAC keystream generator top level.
// A command is taken when start is high and busy is low. A seed load leaves the block idle, so
// loads can follow back to back. A draw holds busy through ST_DRAW_RD and ST_DRAW_OUT, then
// returns its word on random_word with valid high for one cycle, registered from ST_DRAW_OUT,
// when the pool still holds words. A draw with an empty pool first refills it: POOL_WORDS steps
// through the single-port mixing memory, each via ST_RF_RD, ST_RF_A, ST_RF_Y, ST_RF_B, ST_RF_W
// and ST_RF_P. Init first scrambles the eight state words in ST_SCR, then makes two passes of
// 32 blocks (eight reads and adds, eight scramble steps, eight writes each), then a refill.
// After reset a clearing pass zeroes both memories, with busy held high.
// The receiver cannot stall.
module isaac_keystream_generator #(
	parameter int POOL_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] seed_word,
	output logic        valid,
	output logic [31:0] random_word
);

	localparam int AW = $clog2(POOL_WORDS);
	localparam int HALF = POOL_WORDS / 2;

	isaac_pkg::state_t state_q, state_next;

	logic [31:0] mix_mem  [POOL_WORDS];
	logic [31:0] pool_mem [POOL_WORDS];

	logic          mm_we, pm_we;
	logic [AW-1:0] mm_addr, pm_addr;
	logic [31:0]   mm_wdata, pm_wdata;
	logic [31:0]   mm_rdata, pm_rdata;

	always_ff @(posedge clk) begin
		if (mm_we) mix_mem[mm_addr] <= mm_wdata;
		mm_rdata <= mix_mem[mm_addr];
	end

	always_ff @(posedge clk) begin
		if (pm_we) pool_mem[pm_addr] <= pm_wdata;
		pm_rdata <= pool_mem[pm_addr];
	end

	logic [31:0]   a_q, b_q, c_q, x_q, y_q;
	logic [AW:0]   remain_q, seeds_q;
	logic [AW:0]   idx_q;
	logic [2:0]    k_q;
	logic [4:0]    scr_q;
	logic          pass_q;
	logic          init_q;
	isaac_pkg::vec8_t v_q;
	logic [31:0]   out_q;
	logic          valid_q;

	logic [31:0] a_shift;
	always_comb begin
		case (idx_q[1:0])
			2'd0: a_shift = a_q ^ (a_q << 13);
			2'd1: a_shift = a_q ^ (a_q >> 6);
			2'd2: a_shift = a_q ^ (a_q << 2);
			default: a_shift = a_q ^ (a_q >> 16);
		endcase
	end

	logic [31:0] y_sum, b_sum;
	assign y_sum = mm_rdata + a_q + b_q;
	assign b_sum = mm_rdata + x_q;

	logic [AW-1:0] ri;
	assign ri = idx_q[AW-1:0];

	logic draw_empty;
	assign draw_empty = (remain_q == '0);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			isaac_pkg::ST_CLEAR:
				if (idx_q == (AW+1)'(POOL_WORDS - 1)) state_next = isaac_pkg::ST_IDLE;
			isaac_pkg::ST_IDLE:
				if (start) begin
					case (isaac_pkg::opcode_t'(opcode))
						isaac_pkg::OP_INIT: state_next = isaac_pkg::ST_SCR;
						isaac_pkg::OP_DRAW: state_next = draw_empty ?
							isaac_pkg::ST_RF_RD : isaac_pkg::ST_DRAW_RD;
						default: state_next = isaac_pkg::ST_IDLE;
					endcase
				end
			isaac_pkg::ST_SCR:
				if (scr_q == 5'd31) state_next = isaac_pkg::ST_MRD;
			isaac_pkg::ST_MRD: state_next = isaac_pkg::ST_MADD;
			isaac_pkg::ST_MADD:
				state_next = (k_q == 3'd7) ? isaac_pkg::ST_MSCR : isaac_pkg::ST_MRD;
			isaac_pkg::ST_MSCR:
				if (scr_q[2:0] == 3'd7) state_next = isaac_pkg::ST_MWR;
			isaac_pkg::ST_MWR:
				if (k_q == 3'd7) begin
					if (idx_q[AW-1:0] == AW'(POOL_WORDS - 8))
						state_next = pass_q ? isaac_pkg::ST_RF_RD : isaac_pkg::ST_MRD;
					else
						state_next = isaac_pkg::ST_MRD;
				end
			isaac_pkg::ST_RF_RD: state_next = isaac_pkg::ST_RF_A;
			isaac_pkg::ST_RF_A:  state_next = isaac_pkg::ST_RF_Y;
			isaac_pkg::ST_RF_Y:  state_next = isaac_pkg::ST_RF_B;
			isaac_pkg::ST_RF_B:  state_next = isaac_pkg::ST_RF_W;
			isaac_pkg::ST_RF_W:  state_next = isaac_pkg::ST_RF_P;
			isaac_pkg::ST_RF_P:
				if (idx_q == (AW+1)'(POOL_WORDS - 1))
					state_next = init_q ? isaac_pkg::ST_IDLE : isaac_pkg::ST_DRAW_RD;
				else
					state_next = isaac_pkg::ST_RF_RD;
			isaac_pkg::ST_DRAW_RD:  state_next = isaac_pkg::ST_DRAW_OUT;
			isaac_pkg::ST_DRAW_OUT: state_next = isaac_pkg::ST_IDLE;
			default: state_next = isaac_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mm_we = 1'b0;
		mm_addr = ri;
		mm_wdata = '0;
		pm_we = 1'b0;
		pm_addr = ri;
		pm_wdata = '0;
		unique case (state_q)
			isaac_pkg::ST_CLEAR: begin
				mm_we = 1'b1;
				pm_we = 1'b1;
			end
			isaac_pkg::ST_IDLE: begin
				pm_addr = seeds_q[AW-1:0];
				pm_wdata = seed_word;
				pm_we = start && (isaac_pkg::opcode_t'(opcode) == isaac_pkg::OP_LOAD)
					&& (seeds_q < (AW+1)'(POOL_WORDS));
			end
			isaac_pkg::ST_MRD: begin
				mm_addr = AW'(ri + AW'(k_q));
				pm_addr = AW'(ri + AW'(k_q));
			end
			isaac_pkg::ST_MWR: begin
				mm_addr = AW'(ri + AW'(k_q));
				mm_we = 1'b1;
				mm_wdata = v_q[k_q];
			end
			isaac_pkg::ST_RF_RD: mm_addr = ri;
			isaac_pkg::ST_RF_A:  mm_addr = AW'(ri + AW'(HALF));
			isaac_pkg::ST_RF_Y:  mm_addr = x_q[AW+1:2];
			isaac_pkg::ST_RF_B: begin
				mm_addr = ri;
				mm_we = 1'b1;
				mm_wdata = y_sum;
			end
			isaac_pkg::ST_RF_W: mm_addr = y_q[AW+9:10];
			isaac_pkg::ST_RF_P: begin
				pm_addr = ri;
				pm_we = 1'b1;
				pm_wdata = b_sum;
			end
			isaac_pkg::ST_DRAW_RD: pm_addr = AW'(remain_q - 1'b1);
			default: ;
		endcase
	end

	logic [AW:0] k_ext;
	assign k_ext = (AW+1)'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= isaac_pkg::ST_CLEAR;
			idx_q    <= '0;
			k_q      <= '0;
			scr_q    <= '0;
			pass_q   <= 1'b0;
			init_q   <= 1'b0;
			remain_q <= '0;
			seeds_q  <= '0;
			a_q      <= '0;
			b_q      <= '0;
			c_q      <= '0;
			x_q      <= '0;
			y_q      <= '0;
			v_q      <= '0;
			out_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			valid_q <= 1'b0;
			unique case (state_q)
				isaac_pkg::ST_CLEAR: idx_q <= idx_q + 1'b1;
				isaac_pkg::ST_IDLE: begin
					idx_q <= '0;
					k_q <= '0;
					scr_q <= '0;
					pass_q <= 1'b0;
					if (start) begin
						case (isaac_pkg::opcode_t'(opcode))
							isaac_pkg::OP_LOAD:
								if (seeds_q < (AW+1)'(POOL_WORDS)) seeds_q <= seeds_q + 1'b1;
							isaac_pkg::OP_INIT: begin
								init_q <= 1'b1;
								for (int j = 0; j < 8; j++) v_q[j] <= isaac_pkg::GOLDEN;
							end
							isaac_pkg::OP_DRAW: begin
								init_q <= 1'b0;
								if (draw_empty) c_q <= c_q + 1'b1;
								if (draw_empty) b_q <= b_q + c_q + 1'b1;
							end
							default: ;
						endcase
					end
				end
				isaac_pkg::ST_SCR: begin
					v_q <= isaac_pkg::scramble_step(v_q, scr_q[2:0]);
					scr_q <= scr_q + 1'b1;
				end
				isaac_pkg::ST_MRD: ;
				isaac_pkg::ST_MADD: begin
					if (pass_q)
						v_q[k_q] <= v_q[k_q] + mm_rdata;
					else if ((idx_q + k_ext) < seeds_q)
						v_q[k_q] <= v_q[k_q] + pm_rdata;
					k_q <= k_q + 1'b1;
					scr_q <= '0;
				end
				isaac_pkg::ST_MSCR: begin
					v_q <= isaac_pkg::scramble_step(v_q, scr_q[2:0]);
					scr_q <= scr_q + 1'b1;
				end
				isaac_pkg::ST_MWR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7) begin
						if (idx_q[AW-1:0] == AW'(POOL_WORDS - 8)) begin
							idx_q <= '0;
							if (pass_q) begin
								a_q <= '0;
								b_q <= 32'd1;
								c_q <= 32'd1;
								seeds_q <= '0;
							end
							pass_q <= 1'b1;
						end else begin
							idx_q <= idx_q + (AW+1)'(8);
						end
					end
				end
				isaac_pkg::ST_RF_RD: ;
				isaac_pkg::ST_RF_A: begin
					x_q <= mm_rdata;
					a_q <= a_shift;
				end
				isaac_pkg::ST_RF_Y: a_q <= mm_rdata + a_q;
				isaac_pkg::ST_RF_B: y_q <= y_sum;
				isaac_pkg::ST_RF_W: ;
				isaac_pkg::ST_RF_P: begin
					b_q <= b_sum;
					if (idx_q == (AW+1)'(POOL_WORDS - 1)) begin
						idx_q <= '0;
						remain_q <= (AW+1)'(POOL_WORDS);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				isaac_pkg::ST_DRAW_RD: remain_q <= remain_q - 1'b1;
				isaac_pkg::ST_DRAW_OUT: begin
					valid_q <= 1'b1;
					out_q <= pm_rdata;
				end
				default: ;
			endcase
		end
	end

	assign busy = (state_q != isaac_pkg::ST_IDLE);
	assign valid = valid_q;
	assign random_word = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q) == isaac_pkg::ST_DRAW_OUT)
		else $error("valid without draw");
	assert property (@(posedge clk) disable iff (!arst_n)
		remain_q <= (AW+1)'(POOL_WORDS))
		else $error("pool count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		seeds_q <= (AW+1)'(POOL_WORDS))
		else $error("seed count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isaac_pkg::ST_DRAW_RD) |-> remain_q != '0)
		else $error("draw from empty pool");

endmodule
